@@ rtl/gba_pkg.sv @@
// ----------------------------------------------------------------------------
// gba_pkg
// Shared sizes, result codes, count-update bundle and the word scan function
// for the grouped bitmap slot allocator.
// ----------------------------------------------------------------------------
package gba_pkg;

  // Storage geometry
  localparam int GROUPS            = 16;
  localparam int ENTRIES_PER_GROUP = 4096;
  localparam int WORD_BITS         = 64;
  localparam int WORDS_PER_GROUP   = (ENTRIES_PER_GROUP + WORD_BITS - 1) / WORD_BITS;
  localparam int MEM_DEPTH         = GROUPS * WORDS_PER_GROUP;

  localparam int GRP_W   = $clog2(GROUPS);
  localparam int WIDX_W  = $clog2(WORDS_PER_GROUP);
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int ADDR_W  = GRP_W + WIDX_W;
  localparam int CNT_W   = $clog2(ENTRIES_PER_GROUP + 1);
  localparam int WCNT_W  = $clog2(WORDS_PER_GROUP + 1);
  localparam int NG_W    = $clog2(GROUPS + 1);

  // Port field widths
  localparam int MODE_W   = 1;
  localparam int GROUP_W  = 4;
  localparam int OFFSET_W = 12;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;

  // Scan lanes of eight bits
  localparam int LANES  = WORD_BITS / 8;
  localparam int LANE_W = $clog2(LANES);

  // Request kinds
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 1'b0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 1'b1;

  // Result codes
  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;

  // Free count update from the controller
  typedef struct packed {
    logic             dec;
    logic             inc;
    logic [GRP_W-1:0] grp;
  } cnt_upd_t;

  // Lowest clear bit at or above 'from'; result is {found, index}
  function automatic logic [BIT_W:0] find_clear(logic [WORD_BITS-1:0] word,
                                                logic [BIT_W-1:0] from);
    logic [WORD_BITS-1:0] avail;
    logic [LANES-1:0]     lane_any;
    logic [LANE_W-1:0]    lane_sel;
    logic [7:0]           lane_bits;
    logic [2:0]           bit_sel;
    avail = ~word & ({WORD_BITS{1'b1}} << from);
    for (int j = 0; j < LANES; j++) begin
      lane_any[j] = |avail[j*8 +: 8];
    end
    lane_sel = '0;
    for (int j = LANES - 1; j >= 0; j--) begin
      if (lane_any[j]) lane_sel = LANE_W'(j);
    end
    lane_bits = avail[{lane_sel, 3'b000} +: 8];
    bit_sel = '0;
    for (int k = 7; k >= 0; k--) begin
      if (lane_bits[k]) bit_sel = 3'(k);
    end
    return {|lane_any, lane_sel, bit_sel};
  endfunction

endpackage

@@ rtl/gba_bitmap_mem.sv @@
// ----------------------------------------------------------------------------
// gba_bitmap_mem
// Used-bit map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gba_bitmap_mem (
  input  logic                          clk,
  input  logic                          we,
  input  logic [gba_pkg::ADDR_W-1:0]    waddr,
  input  logic [gba_pkg::WORD_BITS-1:0] wdata,
  input  logic                          re,
  input  logic [gba_pkg::ADDR_W-1:0]    raddr,
  output logic [gba_pkg::WORD_BITS-1:0] rdata
);
  import gba_pkg::*;

  logic [WORD_BITS-1:0] mem [MEM_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ rtl/gba_free_count.sv @@
// ----------------------------------------------------------------------------
// gba_free_count
// Per-group free counters: decrement on allocate, saturating increment on
// release, reset to a full group.
// ----------------------------------------------------------------------------
module gba_free_count (
  input  logic                      clk,
  input  logic                      rst,
  input  gba_pkg::cnt_upd_t         upd,
  input  logic [gba_pkg::GRP_W-1:0] rd_grp,
  output logic [gba_pkg::CNT_W-1:0] rd_count
);
  import gba_pkg::*;

  localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES_PER_GROUP);

  logic [CNT_W-1:0] count [GROUPS];

  assign rd_count = count[rd_grp];

  // Counter update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < GROUPS; g++) count[g] <= FULL;
    end else if (upd.dec) begin
      count[upd.grp] <= count[upd.grp] - CNT_W'(1);
    end else if (upd.inc && count[upd.grp] != FULL) begin
      count[upd.grp] <= count[upd.grp] + CNT_W'(1);
    end
  end

endmodule

@@ rtl/grouped_bitmap_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// grouped_bitmap_slot_allocator
// Hinted slot allocator over per-group used-bit maps held in one memory.
// ----------------------------------------------------------------------------
// One request is handled at a time. After reset the block clears the bitmap
// memory (one 64-bit word per cycle) with s_tready low; configuration writes
// are taken throughout. A release reads its word, clears the bit in S_REL and
// then loads the output register in S_DONE. An allocate checks the free count
// of each group tried in S_GRP (also for a group skipped for a zero free
// count), examines one 64-bit word at a time in S_WORD and loads the output
// register in S_DONE: a hit in the hint word ends the scan on that word, while the
// worst case examines 65 words in each group in use. The memory's one read
// port, one word per cycle, sets the pace of the scan. A result waits in an
// output register until taken; a finished result is held until that register
// is free, and the next request is accepted once the controller is back in
// idle.
module grouped_bitmap_slot_allocator (
  input  logic                           clk,
  input  logic                           rst,
  // requests
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,   // group[3:0], offset[15:4]
  input  logic [gba_pkg::MODE_W-1:0]     s_tuser,   // mode[0]
  // results
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,   // slot_group[3:0], slot_offset[15:4]
  output logic [gba_pkg::STATUS_W-1:0]   m_tuser,   // status[1:0]
  // groups_in_use register
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gba_pkg::CFG_W-1:0]      cfg_data
);
  import gba_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_GRP   = 3'd2;
  localparam logic [2:0] S_WORD  = 3'd3;
  localparam logic [2:0] S_REL   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]            state;
  logic [CFG_W-1:0]      groups_in_use;
  logic [ADDR_W-1:0]     clr_addr;
  logic [GRP_W-1:0]      cur_grp;
  logic [WIDX_W-1:0]     word_idx;
  logic [BIT_W-1:0]      from_bit;
  logic [WCNT_W-1:0]     word_cnt;
  logic [NG_W-1:0]       grp_cnt;
  logic [STATUS_W-1:0]   res_status;
  logic [GROUP_W-1:0]    res_group;
  logic [OFFSET_W-1:0]   res_offset;

  logic [NG_W-1:0]       ng;
  logic [GROUP_W-1:0]    in_group;
  logic [OFFSET_W-1:0]   in_offset;
  logic                  in_accept;
  logic [GRP_W-1:0]      next_grp;

  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0]  mem_wdata, mem_rdata;
  cnt_upd_t              upd;
  logic [CNT_W-1:0]      grp_count;
  logic [BIT_W:0]        scan;
  logic                  scan_hit;
  logic [BIT_W-1:0]      scan_bit;
  logic [BIT_W-1:0]      rel_bit;
  logic                  rel_was_set;
  logic                  out_free;

  assign in_group  = s_tdata[3:0];
  assign in_offset = s_tdata[15:4];
  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  // Effective group count: 0 acts as 1, above GROUPS acts as GROUPS
  always_comb begin
    if (groups_in_use == '0) begin
      ng = NG_W'(1);
    end else if (NG_W'(groups_in_use) > NG_W'(GROUPS)) begin
      ng = NG_W'(GROUPS);
    end else begin
      ng = NG_W'(groups_in_use);
    end
  end

  // Group after cur_grp, wrapping at the groups in use
  assign next_grp = (NG_W'(cur_grp) + NG_W'(1) >= ng) ? '0 : cur_grp + GRP_W'(1);

  // Word scan and release bit
  assign scan        = find_clear(mem_rdata, from_bit);
  assign scan_hit    = scan[BIT_W];
  assign scan_bit    = scan[BIT_W-1:0];
  assign rel_bit     = res_offset[BIT_W-1:0];
  assign rel_was_set = mem_rdata[rel_bit];

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      groups_in_use <= CFG_W'(GROUPS);
    end else if (cfg_valid && cfg_ready) begin
      groups_in_use <= cfg_data;
    end
  end

  // Memory port and counter update steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {cur_grp, word_idx};
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = {cur_grp, word_idx};
    upd       = '{dec: 1'b0, inc: 1'b0, grp: cur_grp};
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_IDLE: begin
        mem_re    = in_accept && (s_tuser == MODE_RELEASE);
        mem_raddr = {in_group[GRP_W-1:0], in_offset[BIT_W +: WIDX_W]};
      end
      S_GRP: begin
        mem_re = (grp_count != '0);
      end
      S_WORD: begin
        if (scan_hit) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata | (WORD_BITS'(1) << scan_bit);
          upd.dec   = 1'b1;
        end else begin
          mem_re    = (word_cnt != WCNT_W'(WORDS_PER_GROUP));
          mem_raddr = {cur_grp, word_idx + WIDX_W'(1)};
        end
      end
      S_REL: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata & ~(WORD_BITS'(1) << rel_bit);
        upd.inc   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // S_DONE drives m_tvalid itself
      if (m_tready && state != S_DONE) m_tvalid <= 1'b0;
      case (state)
        // sweep zeros through the bitmap
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_accept) begin
            res_group  <= in_group;
            res_offset <= in_offset;
            word_idx   <= in_offset[BIT_W +: WIDX_W];
            if (s_tuser == MODE_RELEASE) begin
              cur_grp <= in_group[GRP_W-1:0];
              state   <= S_REL;
            end else begin
              cur_grp  <= (NG_W'(in_group) >= ng) ? '0 : in_group[GRP_W-1:0];
              from_bit <= in_offset[BIT_W-1:0];
              word_cnt <= '0;
              grp_cnt  <= NG_W'(1);
              state    <= S_GRP;
            end
          end
        end
        // skip empty groups, otherwise read the first word
        S_GRP: begin
          if (grp_count != '0) begin
            state <= S_WORD;
          end else if (grp_cnt == ng) begin
            res_status <= ST_NO_SPACE;
            res_group  <= '0;
            res_offset <= '0;
            state      <= S_DONE;
          end else begin
            cur_grp  <= next_grp;
            grp_cnt  <= grp_cnt + NG_W'(1);
            word_idx <= '0;
            from_bit <= '0;
          end
        end
        // check the word read last cycle
        S_WORD: begin
          if (scan_hit) begin
            res_status <= ST_OK;
            res_group  <= GROUP_W'(cur_grp);
            res_offset <= OFFSET_W'({word_idx, scan_bit});
            state      <= S_DONE;
          end else if (word_cnt != WCNT_W'(WORDS_PER_GROUP)) begin
            word_idx <= word_idx + WIDX_W'(1);
            word_cnt <= word_cnt + WCNT_W'(1);
            from_bit <= '0;
          end else if (grp_cnt == ng) begin
            res_status <= ST_NO_SPACE;
            res_group  <= '0;
            res_offset <= '0;
            state      <= S_DONE;
          end else begin
            cur_grp  <= next_grp;
            grp_cnt  <= grp_cnt + NG_W'(1);
            word_idx <= '0;
            from_bit <= '0;
            word_cnt <= '0;
            state    <= S_GRP;
          end
        end
        S_REL: begin
          res_status <= rel_was_set ? ST_OK : ST_ALREADY_FREE;
          state      <= S_DONE;
        end
        // hand the result to the output register
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_offset, res_group};
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  gba_bitmap_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  gba_free_count u_count (
    .clk      (clk),
    .rst      (rst),
    .upd      (upd),
    .rd_grp   (cur_grp),
    .rd_count (grp_count)
  );

endmodule

@@ tb/grouped_bitmap_slot_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// grouped_bitmap_slot_allocator_tb
// Self-checking bench for the hinted slot allocator. A slot ledger mirrors the
// used-bit maps, free counts and groups_in_use, and predicts every result.
// Directed beats come first. Mixed allocate/release traffic then runs under
// several groups_in_use settings. Sender bursts and receiver stalls vary
// throughout.
// ----------------------------------------------------------------------------
module grouped_bitmap_slot_allocator_tb;
  import gba_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int REPORT_CAP  = 40;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [3:0]          grp;
    logic [11:0]         off;
  } slot_result_t;

  typedef struct {
    logic [3:0]  grp;
    logic [11:0] off;
  } slot_ref_t;

  // Mirror of the allocator state plus the queue of results still owed
  class slot_ledger;
    logic [WORD_BITS-1:0] used_map [MEM_DEPTH];
    int unsigned          free_cnt [GROUPS];
    logic [CFG_W-1:0]     groups_reg;
    slot_result_t         pending_slots[$];
    slot_ref_t            taken[$];
    int                   result_no;

    function new();
      foreach (used_map[i]) used_map[i] = '0;
      foreach (free_cnt[i]) free_cnt[i] = ENTRIES_PER_GROUP;
      groups_reg = 5'd16;
      result_no  = 0;
    endfunction

    function void set_groups(logic [CFG_W-1:0] v);
      groups_reg = v;
    endfunction

    function int pending();
      return pending_slots.size();
    endfunction

    // lowest clear bit in [from, lim), or -1
    function int lowest_clear(logic [WORD_BITS-1:0] word, int unsigned from,
                              int unsigned lim);
      for (int b = from; b < lim; b++) begin
        if (!word[b]) return b;
      end
      return -1;
    endfunction

    function int unsigned bits_in_word(int unsigned w);
      int unsigned rem;
      rem = ENTRIES_PER_GROUP - w * WORD_BITS;
      return (rem < WORD_BITS) ? rem : WORD_BITS;
    endfunction

    // hint word from the hint bit, then the other words round to the hint word
    function int claim_in_group(int unsigned g, int unsigned hint);
      int unsigned base, w0, w;
      int b;
      base = g * WORDS_PER_GROUP;
      w0   = hint / WORD_BITS;
      b    = lowest_clear(used_map[base + w0], hint % WORD_BITS, bits_in_word(w0));
      if (b >= 0) begin
        used_map[base + w0][b] = 1'b1;
        return w0 * WORD_BITS + b;
      end
      for (int i = 0; i < WORDS_PER_GROUP; i++) begin
        w = (w0 + 1 + i) % WORDS_PER_GROUP;
        b = lowest_clear(used_map[base + w], 0, bits_in_word(w));
        if (b >= 0) begin
          used_map[base + w][b] = 1'b1;
          return w * WORD_BITS + b;
        end
      end
      return -1;
    endfunction

    // accepted request beat: update the mirror and queue the result it owes
    function void accept_request(logic mode, logic [3:0] grp, logic [11:0] off);
      slot_result_t r;
      slot_ref_t    s;
      int unsigned  ng, g, idx;
      int           pos;
      bit           found, was_set;
      if (mode == MODE_ALLOC) begin
        ng = groups_reg;
        if (ng == 0) ng = 1;
        if (ng > GROUPS) ng = GROUPS;
        g = grp;
        if (g >= ng) g = 0;
        found = 0;
        r = '{ST_NO_SPACE, 4'd0, 12'd0};
        for (int i = 0; i < ng && !found; i++) begin
          if (free_cnt[g] > 0) begin
            pos = claim_in_group(g, (i == 0) ? off : 0);
            if (pos >= 0) begin
              free_cnt[g]--;
              r = '{ST_OK, g[3:0], pos[11:0]};
              s = '{g[3:0], pos[11:0]};
              taken.push_back(s);
              found = 1;
            end
          end
          if (!found) begin
            g++;
            if (g >= ng) g = 0;
          end
        end
      end else begin
        idx     = grp * WORDS_PER_GROUP + off / WORD_BITS;
        was_set = used_map[idx][off % WORD_BITS];
        used_map[idx][off % WORD_BITS] = 1'b0;
        if (free_cnt[grp] < ENTRIES_PER_GROUP) free_cnt[grp]++;
        r = '{was_set ? ST_OK : ST_ALREADY_FREE, grp, off};
      end
      pending_slots.push_back(r);
    endfunction

    // compare a result beat with the oldest one owed; 0 and a reason on mismatch
    function bit match_result(slot_result_t got, output string why);
      slot_result_t want;
      why = "";
      result_no++;
      if (pending_slots.size() == 0) begin
        why = $sformatf("result %0d unexpected: status=%0d group=%0d offset=%0d",
                        result_no, got.status, got.grp, got.off);
        return 0;
      end
      want = pending_slots.pop_front();
      if (got.status !== want.status)
        why = {why, $sformatf(" status got %0d want %0d", got.status, want.status)};
      if (got.grp !== want.grp)
        why = {why, $sformatf(" group got %0d want %0d", got.grp, want.grp)};
      if (got.off !== want.off)
        why = {why, $sformatf(" offset got %0d want %0d", got.off, want.off)};
      if (why != "") why = {$sformatf("result %0d:", result_no), why};
      return why == "";
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [15:0]         s_tdata   = '0;  // group[3:0], offset[15:4]
  logic [MODE_W-1:0]   s_tuser   = '0;  // mode[0]
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [15:0]         m_tdata;         // slot_group[3:0], slot_offset[15:4]
  logic [STATUS_W-1:0] m_tuser;         // status[1:0]
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data  = '0;

  slot_ledger ledger = new();
  int mismatch_count = 0;
  int burst_left     = 0;
  int quiet_cycles   = 0;

  grouped_bitmap_slot_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string why);
    if (mismatch_count < REPORT_CAP) $display("MISMATCH %s", why);
    mismatch_count++;
  endtask

  // Result side: check every beat taken
  always @(posedge clk) begin : result_check
    slot_result_t got;
    string        why;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tuser;
      got.grp    = m_tdata[3:0];
      got.off    = m_tdata[15:4];
      if (!ledger.match_result(got, why)) report_mismatch(why);
    end
  end

  // Receiver stalls: one of three ready styles, picked at random
  always @(posedge clk) begin : ready_pattern
    int ready_style, style_left, stall_left;
    if (style_left == 0) begin
      ready_style = $urandom_range(0, 2);
      style_left  = $urandom_range(50, 400);
    end else begin
      style_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      case (ready_style)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 20);
            m_tready <= 1'b0;
          end else begin
            m_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // One request beat, with burst/gap pacing on the sender side
  task automatic send_request(input logic mode, input logic [3:0] grp,
                              input logic [11:0] off);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1, 2:    gap = $urandom_range(1, 3);
        default: gap = $urandom_range(4, 20);
      endcase
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {off, grp};
    do @(posedge clk); while (!s_tready);
    ledger.accept_request(mode, grp, off);
    burst_left--;
  endtask

  // Drop valid and wait until every owed result is back
  task automatic settle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_groups(input logic [CFG_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    ledger.set_groups(v);
    cfg_valid <= 1'b0;
  endtask

  // Mixed traffic: random allocates, releases of held slots, stray releases
  task automatic run_mix(input int count, input int alloc_pct);
    int        pick, sel, span;
    slot_ref_t s;
    logic [11:0] hint;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
        hint = 12'($urandom_range(0, 4095));
        if ($urandom_range(0, 3) == 0) hint[5:0] = 6'h3F;  // end of hint word
        send_request(MODE_ALLOC, 4'($urandom_range(0, 15)), hint);
      end else if (ledger.taken.size() != 0 && pick < 92) begin
        // half the time a recent slot, so later groups see releases too
        if ($urandom_range(0, 1) == 0) begin
          span = (ledger.taken.size() < 64) ? ledger.taken.size() : 64;
          sel  = ledger.taken.size() - 1 - $urandom_range(0, span - 1);
        end else begin
          sel = $urandom_range(0, ledger.taken.size() - 1);
        end
        s = ledger.taken[sel];
        ledger.taken.delete(sel);
        send_request(MODE_RELEASE, s.grp, s.off);
      end else begin
        send_request(MODE_RELEASE, 4'($urandom_range(0, 15)),
                     12'($urandom_range(0, 4095)));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: register above range, hint word edges, wrap inside a group
    write_groups(5'd31);
    send_request(MODE_ALLOC, 4'd0, 12'd0);
    send_request(MODE_ALLOC, 4'd0, 12'd0);
    send_request(MODE_ALLOC, 4'd15, 12'hFFF);
    send_request(MODE_ALLOC, 4'd15, 12'hFFF);
    send_request(MODE_ALLOC, 4'd10, 12'hAAA);
    send_request(MODE_ALLOC, 4'd5, 12'h555);
    send_request(MODE_RELEASE, 4'd15, 12'hFFF);
    send_request(MODE_RELEASE, 4'd15, 12'hFFF);
    send_request(MODE_RELEASE, 4'd3, 12'd0);
    send_request(MODE_RELEASE, 4'd0, 12'd1);
    // register zero acts as one: any hint group lands in group 0
    write_groups(5'd0);
    send_request(MODE_ALLOC, 4'd9, 12'd100);
    send_request(MODE_ALLOC, 4'd15, 12'hFFF);
    write_groups(5'd5);
    send_request(MODE_ALLOC, 4'd7, 12'd63);
    send_request(MODE_ALLOC, 4'd4, 12'd62);
    send_request(MODE_RELEASE, 4'd12, 12'd0);
    send_request(MODE_RELEASE, 4'd4, 12'd62);
    write_groups(5'd16);
    send_request(MODE_ALLOC, 4'd15, 12'hFFF);
    send_request(MODE_ALLOC, 4'd15, 12'h000);
    // two groups in use: hints in each of them
    write_groups(5'd2);
    send_request(MODE_ALLOC, 4'd0, 12'd5);
    send_request(MODE_ALLOC, 4'd1, 12'd9);

    // Random phases over several register settings
    write_groups(5'd16);
    run_mix(170, 60);
    write_groups(5'd3);
    run_mix(120, 55);
    write_groups(5'd31);
    run_mix(120, 50);
    write_groups(5'd0);
    run_mix(100, 50);
    write_groups(5'd1);
    run_mix(80, 45);
    repeat (3) begin
      write_groups(5'($urandom_range(0, 31)));
      run_mix(80, 55);
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && ledger.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/gba_pkg.sv
rtl/gba_bitmap_mem.sv
rtl/gba_free_count.sv
rtl/grouped_bitmap_slot_allocator.sv
tb/grouped_bitmap_slot_allocator_tb.sv
